FILE: hdl/world_to_ndc_projection_defines.svh
// Assertion macros for the world-to-NDC projection block.
`ifndef WORLD_TO_NDC_PROJECTION_DEFINES_SVH
`define WORLD_TO_NDC_PROJECTION_DEFINES_SVH

// Check that a condition implies another at the same edge.
`define WNP_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another at the next edge.
`define WNP_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/wnp_pkg.sv
// Constants and types for the world-to-NDC projection pipeline.
package wnp_pkg;

    localparam int COORD_BITS    = 21;
    localparam int NDC_FRAC_BITS = 12;
    localparam int FIELD_W       = 21;
    localparam int AX_W          = 16;
    localparam int TAN_W         = 16;
    localparam int NDC_W         = 16;
    localparam int QCAP_BITS     = 17;
    localparam int V_W           = COORD_BITS + 1;
    localparam int PROD_W        = V_W + AX_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int NUM_W         = SUM_W + 2 * NDC_FRAC_BITS;
    localparam int DEN_W         = SUM_W - 1 + TAN_W;
    localparam int CMP_W         = DEN_W + QCAP_BITS + 1;
    localparam int Q_W           = QCAP_BITS + 1;
    localparam int DIV_STAGES    = QCAP_BITS + 1;
    localparam int RES_W         = Q_W + 3;

    localparam logic [2:0] REG_CAMERA_POS   = 3'd0;
    localparam logic [2:0] REG_RIGHT_AXIS   = 3'd1;
    localparam logic [2:0] REG_UP_AXIS      = 3'd2;
    localparam logic [2:0] REG_FORWARD_AXIS = 3'd3;
    localparam logic [2:0] REG_TAN_HALF_X   = 3'd4;
    localparam logic [2:0] REG_TAN_HALF_Y   = 3'd5;
    localparam logic [2:0] REG_CENTER_X     = 3'd6;
    localparam logic [2:0] REG_CENTER_Y     = 3'd7;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             done;
    } div_t;

endpackage

FILE: hdl/world_to_ndc_projection.sv
// World point to centered NDC projection, fully pipelined.
//
// Input requests arrive on s_tvalid/s_tready/s_tdata: point x, y, z as signed
// 21-bit fields. Results leave on m_tvalid/m_tready/m_tdata/m_tuser: ndc_x and
// ndc_y in tdata, in_front and on_screen in tuser.
// Camera registers are written through cfg_we/cfg_index/cfg_data; the user must
// write only while the pipeline is empty (the block does not enforce this).
// A write takes effect at the next edge. Stages: camera offset, products, sums,
// divisor multiply, range cap, 17 restoring divide steps (one quotient bit each)
// that set the depth, and output saturation. One point per cycle unless stalled.
// Reset clears all valid bits and loads the default camera: origin, identity
// axes with y forward and z up, unit tangents, zero center.
// When the receiver holds m_tready low with a result pending, the whole
// pipeline holds and s_tready drops; no request is lost or repeated.
`include "world_to_ndc_projection_defines.svh"

module world_to_ndc_projection
    import wnp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [62:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // point_x, point_y, point_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // ndc_x, ndc_y
    output logic [1:0]  m_tuser    // in_front, on_screen
);

    logic [62:0]       camera_pos_reg;
    logic [47:0]       axis_reg [3];
    logic [TAN_W-1:0]  tan_reg [2];
    logic [NDC_W-1:0]  center_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_pos_reg <= '0;
            axis_reg[0]    <= 48'd16384;
            axis_reg[1]    <= 48'd16384 << 32;
            axis_reg[2]    <= 48'd16384 << 16;
            tan_reg[0]     <= TAN_W'(1 << NDC_FRAC_BITS);
            tan_reg[1]     <= TAN_W'(1 << NDC_FRAC_BITS);
            center_reg[0]  <= '0;
            center_reg[1]  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAMERA_POS:   camera_pos_reg <= cfg_data;
                REG_RIGHT_AXIS:   axis_reg[0]    <= cfg_data[47:0];
                REG_UP_AXIS:      axis_reg[1]    <= cfg_data[47:0];
                REG_FORWARD_AXIS: axis_reg[2]    <= cfg_data[47:0];
                REG_TAN_HALF_X:   tan_reg[0]     <= cfg_data[TAN_W-1:0];
                REG_TAN_HALF_Y:   tan_reg[1]     <= cfg_data[TAN_W-1:0];
                REG_CENTER_X:     center_reg[0]  <= cfg_data[NDC_W-1:0];
                REG_CENTER_Y:     center_reg[1]  <= cfg_data[NDC_W-1:0];
                default:          ;
            endcase
        end
    end

    logic en;
    logic v_vld_reg, p_vld_reg, s_vld_reg, d_vld_reg, o_vld_reg;
    logic [DIV_STAGES-1:0] q_vld_reg;

    assign en       = !o_vld_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            q_vld_reg <= '0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v_vld_reg <= s_tvalid;
            p_vld_reg <= v_vld_reg;
            s_vld_reg <= p_vld_reg;
            d_vld_reg <= s_vld_reg;
            q_vld_reg <= {q_vld_reg[DIV_STAGES-2:0], d_vld_reg};
            o_vld_reg <= q_vld_reg[DIV_STAGES-1];
        end
    end

    // camera offset
    logic signed [V_W-1:0] v_next [3];
    logic signed [V_W-1:0] v_reg  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_next[i] = V_W'($signed(s_tdata[i*FIELD_W +: COORD_BITS]))
                      - V_W'($signed(camera_pos_reg[i*COORD_BITS +: COORD_BITS]));
        end
    end

    // products, then axis sums
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [SUM_W-1:0]  sum_next  [3];
    logic signed [SUM_W-1:0]  sum_reg   [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[a][c] = PROD_W'(v_reg[c])
                                * PROD_W'($signed(axis_reg[a][c*AX_W +: AX_W]));
            end
            sum_next[a] = SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1])
                        + SUM_W'(prod_reg[a][2]);
        end
    end

    // divisor and magnitude
    div_t pre_next [2];
    div_t pre_reg  [2];
    logic front_next;
    logic front_reg;

    always_comb
    begin
        front_next = sum_reg[2] > 0;
        for (int k = 0; k < 2; k++)
        begin
            pre_next[k].neg  = sum_reg[k][SUM_W-1];
            pre_next[k].num  = {(sum_reg[k][SUM_W-1] ? SUM_W'(-sum_reg[k])
                                                     : SUM_W'(sum_reg[k])),
                                {(2*NDC_FRAC_BITS){1'b0}}};
            pre_next[k].den  = DEN_W'(sum_reg[2][SUM_W-2:0]) * DEN_W'(tan_reg[k]);
            pre_next[k].q    = '0;
            pre_next[k].done = 1'b0;
        end
    end

    // range cap (stage 0) and restoring divide steps (stages 1..QCAP_BITS)
    div_t dv_next [DIV_STAGES][2];
    div_t dv_reg  [DIV_STAGES][2];
    logic [DIV_STAGES-1:0] fr_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            dv_next[0][k] = pre_reg[k];
            if (pre_reg[k].den == '0)
            begin
                dv_next[0][k].done = 1'b1;
                dv_next[0][k].q    = (pre_reg[k].num != '0) ? Q_W'(1 << QCAP_BITS) : '0;
            end
            else if ((CMP_W'(pre_reg[k].den) << QCAP_BITS) <= CMP_W'(pre_reg[k].num))
            begin
                dv_next[0][k].done = 1'b1;
                dv_next[0][k].q    = Q_W'(1 << QCAP_BITS);
            end
        end
    end

    for (genvar s = 1; s < DIV_STAGES; s++)
    begin : g_div
        logic [CMP_W-1:0] t;
        always_comb
        begin
            for (int k = 0; k < 2; k++)
            begin
                t = CMP_W'(dv_reg[s-1][k].den) << (QCAP_BITS - s);
                dv_next[s][k] = dv_reg[s-1][k];
                if (!dv_reg[s-1][k].done && t <= CMP_W'(dv_reg[s-1][k].num))
                begin
                    dv_next[s][k].num = NUM_W'(CMP_W'(dv_reg[s-1][k].num) - t);
                    dv_next[s][k].q[QCAP_BITS-s] = 1'b1;
                end
            end
        end
    end

    // sign, center offset, saturation
    logic signed [RES_W-1:0] res [2];
    logic [NDC_W-1:0] ndc_next [2];
    logic [NDC_W-1:0] ndc_reg  [2];
    logic onscr_next, onscr_reg, front_out_reg;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            res[k] = dv_reg[DIV_STAGES-1][k].neg
                   ? -$signed(RES_W'(dv_reg[DIV_STAGES-1][k].q))
                   :  $signed(RES_W'(dv_reg[DIV_STAGES-1][k].q));
            res[k] = res[k] - RES_W'($signed(center_reg[k]));
            if (!fr_reg[DIV_STAGES-1])
                ndc_next[k] = '0;
            else if (res[k] > RES_W'(32767))
                ndc_next[k] = 16'h7fff;
            else if (res[k] < -RES_W'(32768))
                ndc_next[k] = 16'h8000;
            else
                ndc_next[k] = res[k][NDC_W-1:0];
        end
        onscr_next = fr_reg[DIV_STAGES-1];
        for (int k = 0; k < 2; k++)
        begin
            if ($signed(ndc_next[k]) > $signed(NDC_W'(1 << NDC_FRAC_BITS)) ||
                $signed(ndc_next[k]) < -$signed(NDC_W'(1 << NDC_FRAC_BITS)))
                onscr_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg         <= v_next;
            prod_reg      <= prod_next;
            sum_reg       <= sum_next;
            pre_reg       <= pre_next;
            front_reg     <= front_next;
            dv_reg        <= dv_next;
            fr_reg        <= {fr_reg[DIV_STAGES-2:0], front_reg};
            ndc_reg       <= ndc_next;
            onscr_reg     <= onscr_next;
            front_out_reg <= fr_reg[DIV_STAGES-1];
        end
    end

    assign m_tvalid = o_vld_reg;
    assign m_tdata  = {ndc_reg[1], ndc_reg[0]};
    assign m_tuser  = {onscr_reg, front_out_reg};

    `WNP_ASSERT_NOW(a_behind_zero, clk, rst_n, m_tvalid && !m_tuser[0],
        m_tdata == '0, "behind-camera result has nonzero NDC")
    `WNP_ASSERT_NOW(a_onscr_front, clk, rst_n, m_tvalid && m_tuser[1],
        m_tuser[0], "on_screen set while behind camera")
    `WNP_ASSERT_NEXT(a_accept_enters, clk, rst_n, s_tvalid && s_tready,
        v_vld_reg, "accepted request did not enter pipeline")

endmodule
